@@ hdl/pcs_pkg.sv @@
// Package for the percentile contrast stretch block: request and result
// structs, function codes and fixed widths. No dependencies.
package pcs_pkg;

  typedef enum logic [1:0] {
    FUNC_ACCUM  = 2'd0,
    FUNC_FINISH = 2'd1,
    FUNC_MAP    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [10:0] low_bin;
    logic [10:0] high_bin;
    logic [7:0]  stretched;
  } out_res_t;

endpackage

@@ hdl/pcs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the binning and map
// paths. Depends on nothing outside this file.
module pcs_div #(
  parameter int NW = 64,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   trial;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial = {r_r, q_r[NW-1]} - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= num;
        r_r    <= '0;
        d_r    <= den;
      end else if (busy_r) begin
        if (!trial[DW]) begin
          r_r <= trial[DW-1:0];
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          r_r <= {r_r[DW-2:0], q_r[NW-1]};
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
  assign rem = r_r;

endmodule

@@ hdl/pcs_hist.sv @@
// Histogram memory: one synchronous RAM of bin counts with a registered read.
// Depends on nothing outside this file.
module pcs_hist #(
  parameter int BINS = 1024,
  parameter int CNTW = 25
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(BINS)-1:0] waddr,
  input  logic [CNTW-1:0]         wdata,
  input  logic [$clog2(BINS)-1:0] raddr,
  output logic [CNTW-1:0]         rdata
);

  logic [CNTW-1:0] mem [BINS];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/percentile_contrast_stretch_core.sv @@
// Percentile contrast stretch, top level. Uses pcs_pkg, pcs_div, pcs_hist.
//
// One request at a time. After reset the block clears its histogram RAM, one
// bin per cycle, before it takes the first request. An accumulate uses a
// 64-step divider to find the bin, then a read and write of the RAM; one
// outside the histogram range skips both. A map uses the same 64-step
// divider, unless the bounds, the scale or the sample leave nothing to
// divide. A finish reads every bin once and clears it behind the read.
// A new request also waits while a result is held on the output. The scale
// register may be written at any idle time.
module percentile_contrast_stretch_core #(
  parameter int BINS       = 1024,
  parameter int MAX_PIXELS = 16777216
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcs_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pcs_pkg::out_res_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  localparam int AW   = $clog2(BINS);
  localparam int BW   = AW + 1;
  localparam int CNTW = $clog2(MAX_PIXELS) + 1;
  localparam int SW   = CNTW + 6;  // room for 20 * cumulative count
  localparam int AN   = 32 + AW;   // accumulate dividend width
  localparam int MN   = 64;        // map dividend width
  localparam int MD   = BW + 32;   // map divisor width

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACC_DIV, ST_ACC_RD, ST_ACC_WR, ST_FIN_RD,
    ST_FIN_WALK, ST_MAP_PRE, ST_MAP_DIV, ST_OUT
  } state_t;

  state_t            state_r;
  logic [31:0]       scale_r;
  logic [CNTW-1:0]   total_r;
  logic [BW-1:0]     low_r, high_r;
  logic [AW-1:0]     idx_r;
  logic [AW:0]       walk_r;
  logic [SW-1:0]     cum_r;
  logic              lo_found_r, hi_found_r;
  logic signed [65:0] mnum_r;
  logic [MD-1:0]     mden_r;
  pcs_pkg::out_res_t res_r;
  logic              out_valid_r;

  // Memory and divider hookup.
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CNTW-1:0] wdata, rdata;
  logic            div_start, div_done;
  logic [MN-1:0]   div_num, div_quo;
  logic [MD-1:0]   div_den, div_rem;
  logic [SW-1:0]   cum_nxt;
  logic [SW+4:0]   cum20;
  logic [SW+4:0]   n19;
  logic [MD:0]     rem2;
  logic [MN-1:0]   q_rnd;
  logic [MD-1:0]   lo_scaled;

  pcs_hist #(.BINS(BINS), .CNTW(CNTW)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  pcs_div #(.NW(MN), .DW(MD)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Histogram port control: clearing sweep, bin update and walk-behind clear.
  always_comb begin
    raddr = (state_r == ST_FIN_RD || state_r == ST_FIN_WALK) ? walk_r[AW-1:0] : idx_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_ACC_WR: begin
        we    = 1'b1;
        wdata = (rdata < CNTW'(MAX_PIXELS)) ? rdata + 1'b1 : rdata;
      end
      ST_FIN_WALK: begin
        we    = 1'b1;
        waddr = walk_r[AW-1:0] - 1'b1;
      end
      default: ;
    endcase
  end

  // Divider operands: bin index for accumulate, scaled offset for map.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == ST_IDLE && in_valid && !out_valid_r &&
        in_data.func == pcs_pkg::FUNC_ACCUM) begin
      div_start = in_data.sample >= 0 && $unsigned(in_data.sample) < scale_r;
      div_num   = MN'(in_data.sample[31:0]) * MN'(BINS);
      div_den   = MD'(scale_r);
    end else if (state_r == ST_MAP_PRE) begin
      div_start = 1'b1;
      div_num   = MN'(mnum_r * 66'sd255);
      div_den   = MD'(high_r - low_r) * MD'(scale_r);
    end
  end

  // Walk arithmetic, low bound offset and round-half-even.
  always_comb begin
    cum_nxt   = cum_r + SW'(rdata);
    cum20     = (SW+5)'({cum_nxt, 4'b0}) + (SW+5)'({cum_nxt, 2'b0});
    n19       = (SW+5)'(total_r) * (SW+5)'(19);
    lo_scaled = MD'(low_r) * MD'(scale_r);
    rem2      = {div_rem, 1'b0};
    q_rnd     = div_quo;
    if (rem2 > {1'b0, mden_r} || (rem2 == {1'b0, mden_r} && div_quo[0])) begin
      q_rnd = div_quo + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scale_r     <= 32'd65535;
      total_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == AW'(BINS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && !out_valid_r) begin
            case (in_data.func)
              pcs_pkg::FUNC_ACCUM: begin
                if (total_r < CNTW'(MAX_PIXELS)) total_r <= total_r + 1'b1;
                if (div_start) state_r <= ST_ACC_DIV;
              end
              pcs_pkg::FUNC_FINISH: begin
                walk_r     <= '0;
                cum_r      <= '0;
                lo_found_r <= 1'b0;
                hi_found_r <= 1'b0;
                low_r      <= BW'(BINS);
                high_r     <= BW'(BINS);
                state_r    <= ST_FIN_RD;
              end
              pcs_pkg::FUNC_MAP: begin
                mnum_r  <= 66'(in_data.sample) * 66'(BINS)
                           - 66'($signed({1'b0, lo_scaled}));
                state_r <= ST_MAP_PRE;
              end
              default: ;
            endcase
          end
        end
        ST_ACC_DIV: begin
          if (div_done) begin
            idx_r   <= div_quo[AW-1:0];
            state_r <= ST_ACC_RD;
          end
        end
        ST_ACC_RD: state_r <= ST_ACC_WR;
        ST_ACC_WR: state_r <= ST_IDLE;
        ST_FIN_RD: begin
          walk_r  <= walk_r + 1'b1;
          state_r <= ST_FIN_WALK;
        end
        ST_FIN_WALK: begin
          cum_r <= cum_nxt;
          if (!lo_found_r && cum20 > (SW+5)'(total_r)) begin
            lo_found_r <= 1'b1;
            low_r      <= BW'(walk_r - 1'b1);
          end
          if (!hi_found_r && cum20 > n19) begin
            hi_found_r <= 1'b1;
            high_r     <= BW'(walk_r - 1'b1);
          end
          if (walk_r == (AW+1)'(BINS)) begin
            total_r <= '0;
            state_r <= ST_OUT;
            res_r.stretched <= '0;
          end else begin
            walk_r <= walk_r + 1'b1;
          end
        end
        ST_MAP_PRE: begin
          mden_r <= div_den;
          if (high_r <= low_r || scale_r == '0 || mnum_r <= 0) begin
            res_r.low_bin   <= '0;
            res_r.high_bin  <= '0;
            res_r.stretched <= (mnum_r > 0) ? 8'd255 : 8'd0;
            out_valid_r     <= 1'b1;
            state_r         <= ST_IDLE;
          end else begin
            state_r <= ST_MAP_DIV;
          end
        end
        ST_MAP_DIV: begin
          if (div_done) begin
            res_r.low_bin   <= '0;
            res_r.high_bin  <= '0;
            res_r.stretched <= (q_rnd > MN'(255)) ? 8'd255 : q_rnd[7:0];
            out_valid_r     <= 1'b1;
            state_r         <= ST_IDLE;
          end
        end
        ST_OUT: begin
          res_r.low_bin  <= low_r;
          res_r.high_bin <= high_r;
          out_valid_r    <= 1'b1;
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ verif/percentile_contrast_stretch_core_test.sv @@
// Testbench for percentile_contrast_stretch_core: drives accumulate, finish and
// map requests, predicts each result and checks it. Depends on pcs_pkg and the core.
module percentile_contrast_stretch_core_test;

  localparam int NBINS    = 1024;
  localparam int PIX_MAX  = 16777216;
  localparam int IDLE_MAX = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pcs_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pcs_pkg::out_res_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data = '0;

  percentile_contrast_stretch_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [31:0]       range_top;
  int unsigned       hist [NBINS];
  int unsigned       total_px;
  int unsigned       lo_edge, hi_edge;
  pcs_pkg::out_res_t pending_res [$];
  int                errors = 0;
  bit                long_hold = 1'b0;
  int                quiet = 0;

  // Rounded, saturated stretch of one sample.
  function automatic logic [7:0] stretch_px(longint v);
    longint num;
    longint unsigned d, q, r;
    num = v * NBINS - longint'(lo_edge) * longint'(range_top);
    if (hi_edge <= lo_edge || range_top == 0) return (num > 0) ? 8'd255 : 8'd0;
    if (num <= 0) return 8'd0;
    num = num * 255;
    d = longint'(hi_edge - lo_edge) * longint'(range_top);
    q = longint'(num) / d;
    r = longint'(num) % d;
    if (2 * r > d || (2 * r == d && q[0])) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Update the histogram model with one request and queue its result, if it has one.
  task automatic predict_req(pcs_pkg::in_req_t rq);
    longint v;
    longint unsigned cum, idx;
    pcs_pkg::out_res_t res;
    v = rq.sample;
    res = '0;
    case (pcs_pkg::func_t'(rq.func))
      pcs_pkg::FUNC_ACCUM: begin
        if (total_px < PIX_MAX) total_px++;
        if (v >= 0 && v < longint'(range_top)) begin
          idx = (longint'(v) * NBINS) / range_top;
          if (hist[idx] < PIX_MAX) hist[idx]++;
        end
      end
      pcs_pkg::FUNC_FINISH: begin
        cum = 0;
        lo_edge = NBINS;
        hi_edge = NBINS;
        for (int j = 0; j < NBINS; j++) begin
          cum += hist[j];
          if (lo_edge == NBINS && 20 * cum > total_px) lo_edge = j;
          if (hi_edge == NBINS && 20 * cum > 19 * longint'(total_px)) hi_edge = j;
          hist[j] = 0;
        end
        total_px = 0;
        res.low_bin = 11'(lo_edge);
        res.high_bin = 11'(hi_edge);
        pending_res.push_back(res);
      end
      pcs_pkg::FUNC_MAP: begin
        res.stretched = stretch_px(v);
        pending_res.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Send one request, with a random gap before it. The request stays
  // offered after acceptance until the next request or a drain replaces it.
  task automatic send_req(pcs_pkg::func_t f, logic [31:0] s);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.func <= f;
    in_data.sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_req('{func: f, sample: s});
  endtask

  // Wait for all results, then let the block settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    range_top = val;
  endtask

  // Random sample biased toward the histogram range.
  function automatic logic [31:0] rand_px();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b1, 31'($urandom())};
      2: return range_top + $urandom_range(0, 3);
      default: return (range_top == 0) ? 32'd0 : $urandom_range(0, range_top - 1);
    endcase
  endfunction

  // Extremes, every function code and each special case.
  task automatic test_directed();
    send_req(pcs_pkg::FUNC_MAP, 32'd100);
    send_req(pcs_pkg::FUNC_FINISH, 32'd0);
    send_req(pcs_pkg::FUNC_MAP, 32'd0);
    send_req(pcs_pkg::FUNC_MAP, 32'h7FFF_FFFF);
    send_req(pcs_pkg::FUNC_MAP, 32'h8000_0000);
    send_req(pcs_pkg::FUNC_ACCUM, 32'd0);
    send_req(pcs_pkg::FUNC_ACCUM, 32'd65534);
    send_req(pcs_pkg::FUNC_ACCUM, 32'd65535);
    send_req(pcs_pkg::FUNC_ACCUM, 32'hFFFF_FFFF);
    send_req(pcs_pkg::FUNC_ACCUM, 32'h8000_0000);
    send_req(pcs_pkg::FUNC_ACCUM, 32'h7FFF_FFFF);
    send_req(pcs_pkg::FUNC_NONE, 32'h5555_AAAA);
    send_req(pcs_pkg::FUNC_NONE, 32'hAAAA_5555);
    send_req(pcs_pkg::FUNC_ACCUM, 32'd30000);
    send_req(pcs_pkg::FUNC_FINISH, 32'hFFFF_FFFF);
    send_req(pcs_pkg::FUNC_MAP, 32'd0);
    send_req(pcs_pkg::FUNC_MAP, 32'd32768);
    send_req(pcs_pkg::FUNC_MAP, 32'd65534);
    send_req(pcs_pkg::FUNC_MAP, 32'hFFFF_FFFF);
  endtask

  // Well-formed images: an accumulate pass, a finish, then a map pass.
  task automatic test_images(int n_img);
    int n;
    for (int i = 0; i < n_img; i++) begin
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) send_req(pcs_pkg::FUNC_NONE, $urandom());
        else send_req(pcs_pkg::FUNC_ACCUM, rand_px());
      end
      send_req(pcs_pkg::FUNC_FINISH, $urandom());
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) send_req(pcs_pkg::FUNC_MAP, rand_px());
    end
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int k = 0; k < 6; k++) send_req(pcs_pkg::FUNC_MAP, rand_px());
    long_hold = 1'b0;
  endtask

  initial begin
    range_top = 32'd65535;
    total_px = 0;
    lo_edge = 0;
    hi_edge = 0;
    foreach (hist[j]) hist[j] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_images(18);
    write_scale(32'd1);
    test_images(4);
    write_scale(32'hFFFF_FFFF);
    test_images(9);
    write_scale(32'd1000);
    test_images(12);
    write_scale(32'd2048);
    test_images(12);
    drain();
    if (errors == 0) $display("percentile_contrast_stretch_core_test OK");
    else $display("percentile_contrast_stretch_core_test NOT OK");
    $finish;
  end

  // Receiver stall pattern, including one long hold-off of a counted length.
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        while (long_hold) @(posedge clk);
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) len = 0;
        out_stall <= (len != 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    pcs_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (out_data.low_bin !== want.low_bin) begin
          $error("low_bin expected %0d got %0d", want.low_bin, out_data.low_bin);
          errors++;
        end
        if (out_data.high_bin !== want.high_bin) begin
          $error("high_bin expected %0d got %0d", want.high_bin, out_data.high_bin);
          errors++;
        end
        if (out_data.stretched !== want.stretched) begin
          $error("stretched expected %0d got %0d", want.stretched, out_data.stretched);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request, register write or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_MAX) begin
      $display("percentile_contrast_stretch_core_test NOT OK");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/pcs_pkg.sv
hdl/pcs_div.sv
hdl/pcs_hist.sv
hdl/percentile_contrast_stretch_core.sv
verif/percentile_contrast_stretch_core_test.sv
